// ===== hw/rtl/chaos_pkg.sv =====
// Package for the chaos-game walker core: command codes, stage control,
// register layout and default sizes. No dependencies.
package chaos_pkg;

	localparam int ANCHOR_COUNT_DEF = 16;
	localparam int COORD_BITS_DEF   = 32;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam int                 FACTOR_W     = 17;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 17'h10000;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'h08000;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_STEP  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic hit;
	} ctl_t;

endpackage

// ===== hw/rtl/chaos_game_step_with_bounds_core.sv =====
// Chaos-game walker core: anchor memory, point update and bounding box.
// Depends on chaos_pkg.
// Throughput: one item per cycle while out_stall is low; bounded by the point
// update, one multiply-add per cycle on the stored point.
// Reset: stages empty, point and box zero, step_factor 32768; anchor table
// undefined until loaded.
module chaos_game_step_with_bounds_core
	import chaos_pkg::*;
#(
	parameter int ANCHOR_COUNT = ANCHOR_COUNT_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_ADDR_W-1:0]        paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   command,
	input  logic [3:0]                   anchor_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] pos_x,
	output logic signed [COORD_BITS-1:0] pos_y,
	output logic signed [COORD_BITS-1:0] min_x,
	output logic signed [COORD_BITS-1:0] max_x,
	output logic signed [COORD_BITS-1:0] min_y,
	output logic signed [COORD_BITS-1:0] max_y
);

	localparam int IDX_W = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
	localparam int PW    = COORD_BITS + FACTOR_W + 1;

	// configuration
	logic [FACTOR_W-1:0] factor_q;
	logic [FACTOR_W-1:0] f_sat;
	logic [FACTOR_W-1:0] g_sat;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : APB_DATA_W'(factor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			factor_q <= pwdata[FACTOR_W-1:0];
		end
	end

	assign f_sat = (factor_q > FACTOR_ONE) ? FACTOR_ONE : factor_q;
	assign g_sat = FACTOR_ONE - f_sat;

	// stage enables
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic en_s1, en_s2, en_s3, en_out;
	logic accept;

	assign en_out   = !out_valid_q || !out_stall;
	assign en_s3    = !valid_s3 || en_out;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;

	// decode
	logic [8:0]       idx_wide;
	logic [IDX_W-1:0] addr;
	ctl_t             ctl_in;

	assign idx_wide     = 9'(anchor_index);
	assign addr         = idx_wide[IDX_W-1:0];
	assign ctl_in.load  = (command == CMD_LOAD);
	assign ctl_in.start = (command == CMD_START);
	assign ctl_in.step  = (command == CMD_STEP);
	assign ctl_in.hit   = (idx_wide < 9'(ANCHOR_COUNT));

	// anchor memory, x in the upper half
	logic [2*COORD_BITS-1:0] anchor_mem [ANCHOR_COUNT];
	logic [2*COORD_BITS-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (accept && ctl_in.load && ctl_in.hit) begin
			anchor_mem[addr] <= {coord_x, coord_y};
		end
		if (en_s1) begin
			rd_s1 <= anchor_mem[addr];
		end
	end

	// stage 1: anchor read
	ctl_t                         ctl_s1;
	logic signed [COORD_BITS-1:0] cx_s1, cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_in;
			cx_s1  <= coord_x;
			cy_s1  <= coord_y;
		end
	end

	// stage 2: anchor times factor
	ctl_t                         ctl_s2;
	logic signed [COORD_BITS-1:0] cx_s2, cy_s2;
	logic signed [PW-1:0]         af_x_s2, af_y_s2;
	logic signed [COORD_BITS-1:0] ax_s1, ay_s1;
	logic signed [FACTOR_W:0]     fs_s1;

	assign ax_s1 = rd_s1[2*COORD_BITS-1:COORD_BITS];
	assign ay_s1 = rd_s1[COORD_BITS-1:0];
	assign fs_s1 = {1'b0, f_sat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			ctl_s2  <= ctl_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			af_x_s2 <= PW'(ax_s1 * fs_s1);
			af_y_s2 <= PW'(ay_s1 * fs_s1);
		end
	end

	// stage 3: point update, point*(1-f) + anchor*f
	ctl_t                         ctl_s3;
	logic signed [COORD_BITS-1:0] point_x_q, point_y_q;
	logic signed [FACTOR_W:0]     gs;
	logic signed [PW:0]           sum_x, sum_y;

	assign gs    = {1'b0, g_sat};
	assign sum_x = (PW+1)'(point_x_q * gs) + (PW+1)'(af_x_s2);
	assign sum_y = (PW+1)'(point_y_q * gs) + (PW+1)'(af_y_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			point_x_q <= '0;
			point_y_q <= '0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
			if (valid_s2) begin
				if (ctl_s2.start) begin
					point_x_q <= cx_s2;
					point_y_q <= cy_s2;
				end else if (ctl_s2.step && ctl_s2.hit) begin
					point_x_q <= sum_x[COORD_BITS+15:16];
					point_y_q <= sum_y[COORD_BITS+15:16];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			ctl_s3 <= ctl_s2;
		end
	end

	// output register and bounding box
	logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q;
	logic signed [COORD_BITS-1:0] low_x_q, high_x_q, low_y_q, high_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			low_x_q     <= '0;
			high_x_q    <= '0;
			low_y_q     <= '0;
			high_y_q    <= '0;
		end else if (en_out) begin
			out_valid_q <= valid_s3 && (ctl_s3.start || ctl_s3.step);
			if (valid_s3 && ctl_s3.start) begin
				low_x_q  <= point_x_q;
				high_x_q <= point_x_q;
				low_y_q  <= point_y_q;
				high_y_q <= point_y_q;
			end else if (valid_s3 && ctl_s3.step) begin
				if (point_x_q < low_x_q)  low_x_q  <= point_x_q;
				if (point_x_q > high_x_q) high_x_q <= point_x_q;
				if (point_y_q < low_y_q)  low_y_q  <= point_y_q;
				if (point_y_q > high_y_q) high_y_q <= point_y_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s3 && (ctl_s3.start || ctl_s3.step)) begin
			pos_x_q <= point_x_q;
			pos_y_q <= point_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign min_x     = low_x_q;
	assign max_x     = high_x_q;
	assign min_y     = low_y_q;
	assign max_y     = high_y_q;

	// checks
	a_box_holds_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (low_x_q <= pos_x_q && pos_x_q <= high_x_q &&
			low_y_q <= pos_y_q && pos_y_q <= high_y_q))
		else $error("bounding box does not contain the reported point");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && ctl_s3.load && en_out) |=> !out_valid_q)
		else $error("load produced a result transfer");

	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s2 && en_s3) |=> ($stable(point_x_q) && $stable(point_y_q)))
		else $error("point changed without an item entering stage 3");

endmodule

// ===== tb/chaos_walk_checker.sv =====
// Scoreboard for the chaos-game walker core: follows register writes and input
// transfers, predicts each result and compares it with the output transfer.
// Depends on chaos_pkg.
`timescale 1ns / 100ps
module chaos_walk_checker
	import chaos_pkg::*;
#(
	parameter int                    ANCHOR_COUNT = ANCHOR_COUNT_DEF,
	parameter int                    COORD_BITS   = COORD_BITS_DEF,
	parameter logic [APB_ADDR_W-1:0] FACTOR_ADDR  = '0
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [APB_ADDR_W-1:0]        paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,

	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [1:0]                   command,
	input  logic [3:0]                   anchor_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,

	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] min_x,
	input  logic signed [COORD_BITS-1:0] max_x,
	input  logic signed [COORD_BITS-1:0] min_y,
	input  logic signed [COORD_BITS-1:0] max_y,

	output int                           fail_count,
	output int                           pending
);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [6*COORD_BITS-1:0]      walk_result_t;

	coord_t              anchor_x [ANCHOR_COUNT];
	coord_t              anchor_y [ANCHOR_COUNT];
	coord_t              here_x, here_y, lo_x, hi_x, lo_y, hi_y;
	logic [FACTOR_W-1:0] factor;
	walk_result_t        expected_walk [$];
	int                  errors;
	string               field_name [6] = '{"pos_x", "pos_y", "min_x", "max_x", "min_y", "max_y"};

	// old + floor((target - old) * f / 65536)
	function automatic coord_t walk_toward(coord_t from, coord_t target,
			logic [FACTOR_W-1:0] f);
		longint span;
		longint share;
		span  = longint'(target) - longint'(from);
		share = (span * longint'(f)) >>> 16;
		return coord_t'(longint'(from) + share);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		walk_result_t        got;
		walk_result_t        want;
		logic [FACTOR_W-1:0] eff;
		if (!arst_n) begin
			here_x = '0;
			here_y = '0;
			lo_x   = '0;
			hi_x   = '0;
			lo_y   = '0;
			hi_y   = '0;
			factor = FACTOR_RESET;
			errors = 0;
			expected_walk.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {pos_x, pos_y, min_x, max_x, min_y, max_y};
				if (expected_walk.size() == 0) begin
					errors++;
					$error("result transfer with no command waiting for it");
				end else begin
					want = expected_walk.pop_front();
					for (int i = 0; i < 6; i++) begin
						if (got[(5-i)*COORD_BITS +: COORD_BITS] !=
								want[(5-i)*COORD_BITS +: COORD_BITS]) begin
							errors++;
							$error("%s: expected %0d, got %0d", field_name[i],
								$signed(want[(5-i)*COORD_BITS +: COORD_BITS]),
								$signed(got[(5-i)*COORD_BITS +: COORD_BITS]));
						end
					end
				end
			end

			if (in_valid && !in_stall) begin
				case (command)
					CMD_LOAD: begin
						if (anchor_index < ANCHOR_COUNT) begin
							anchor_x[anchor_index] = coord_x;
							anchor_y[anchor_index] = coord_y;
						end
					end
					CMD_START: begin
						here_x = coord_x;
						here_y = coord_y;
						lo_x   = coord_x;
						hi_x   = coord_x;
						lo_y   = coord_y;
						hi_y   = coord_y;
						expected_walk.push_back({here_x, here_y, lo_x, hi_x, lo_y, hi_y});
					end
					CMD_STEP: begin
						if (anchor_index < ANCHOR_COUNT) begin
							eff    = (factor > FACTOR_ONE) ? FACTOR_ONE : factor;
							here_x = walk_toward(here_x, anchor_x[anchor_index], eff);
							here_y = walk_toward(here_y, anchor_y[anchor_index], eff);
							if (here_x < lo_x) lo_x = here_x;
							if (here_x > hi_x) hi_x = here_x;
							if (here_y < lo_y) lo_y = here_y;
							if (here_y > hi_y) hi_y = here_y;
						end
						expected_walk.push_back({here_x, here_y, lo_x, hi_x, lo_y, hi_y});
					end
					default: ;
				endcase
			end

			if (psel && penable && pwrite && pready && paddr == FACTOR_ADDR)
				factor = pwdata[FACTOR_W-1:0];

			fail_count <= errors;
			pending    <= expected_walk.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the chaos-game walker core: clock, reset, register writes,
// command stimulus with random idling, and the verdict.
// Depends on chaos_pkg, chaos_game_step_with_bounds_core and chaos_walk_checker.
`timescale 1ns / 100ps
module tb_top;
	import chaos_pkg::*;

	localparam int                    ANCHOR_COUNT     = ANCHOR_COUNT_DEF;
	localparam int                    COORD_BITS       = COORD_BITS_DEF;
	localparam logic [APB_ADDR_W-1:0] ADDR_STEP_FACTOR = '0;
	localparam logic [1:0]            CMD_SPARE        = 2'd3;
	localparam int                    PIPE_LATENCY     = 4;
	localparam int                    CYCLE_LIMIT      = 400000;
	localparam int                    PHASES           = 10;
	localparam int                    PHASE_ITEMS      = 95;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0] paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [1:0]            command      = '0;
	logic [3:0]            anchor_index = '0;
	coord_t                coord_x      = '0;
	coord_t                coord_y      = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	coord_t                pos_x, pos_y, min_x, max_x, min_y, max_y;

	int                fail_count;
	int                pending;
	int                cycles       = 0;
	int                stall_left   = 0;
	int                run_left     = 0;
	int                gap_odds     = 4;
	bit                quiet        = 1'b0;
	logic [15:0]       loaded       = '0;
	int                n_load, n_start, n_step, n_spare, n_write;

	chaos_game_step_with_bounds_core #(
		.ANCHOR_COUNT (ANCHOR_COUNT),
		.COORD_BITS   (COORD_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.anchor_index (anchor_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.min_x        (min_x),
		.max_x        (max_x),
		.min_y        (min_y),
		.max_y        (max_y)
	);

	chaos_walk_checker #(
		.ANCHOR_COUNT (ANCHOR_COUNT),
		.COORD_BITS   (COORD_BITS),
		.FACTOR_ADDR  (ADDR_STEP_FACTOR)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.anchor_index (anchor_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.min_x        (min_x),
		.max_x        (max_x),
		.min_y        (min_y),
		.max_y        (max_y),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// hold off result transfers in bursts, with long free-running stretches
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (run_left > 0) begin
			out_stall <= 1'b0;
			run_left = run_left - 1;
		end else begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 17);
			run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
			                                         : $urandom_range(0, 12);
		end
	end

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0:       return COORD_MAX;
			1:       return COORD_MIN;
			2:       return coord_t'(int'($urandom_range(0, 131072)) - 65536);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic send(logic [1:0] cmd, logic [3:0] idx, coord_t x, coord_t y);
		int gap;
		gap = (!quiet && $urandom_range(1, gap_odds) == 1) ? $urandom_range(1, 18) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		anchor_index <= idx;
		coord_x      <= x;
		coord_y      <= y;
		do @(posedge clk); while (in_stall);
		case (cmd)
			CMD_LOAD: begin
				loaded[idx] = 1'b1;
				n_load++;
			end
			CMD_START: n_start++;
			CMD_STEP:  n_step++;
			default:   n_spare++;
		endcase
	endtask

	// drop valid and drain every outstanding result, then the pipeline itself
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_factor(logic [FACTOR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_STEP_FACTOR;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		n_write++;
	endtask

	task automatic random_item();
		int         pick;
		logic [3:0] slot;
		pick = $urandom_range(0, 99);
		slot = 4'($urandom);
		if (pick < 15) begin
			send(CMD_LOAD, slot, rand_coord(), rand_coord());
		end else if (pick < 25) begin
			send(CMD_START, slot, rand_coord(), rand_coord());
		end else if (pick < 95) begin
			while (!loaded[slot]) slot = 4'($urandom);
			send(CMD_STEP, slot, rand_coord(), rand_coord());
		end else begin
			send(CMD_SPARE, slot, rand_coord(), rand_coord());
		end
	endtask

	initial begin
		logic [FACTOR_W-1:0] f;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_LOAD,  4'd0,  COORD_MAX, COORD_MAX);
		send(CMD_STEP,  4'd0,  '0, '0);
		send(CMD_LOAD,  4'd15, COORD_MIN, COORD_MIN);
		send(CMD_LOAD,  4'd10, -1, 1);
		send(CMD_LOAD,  4'd5,  '0, '0);
		send(CMD_START, 4'd0,  COORD_MIN, COORD_MIN);
		send(CMD_STEP,  4'd0,  COORD_MAX, COORD_MIN);
		send(CMD_STEP,  4'd15, '0, '0);
		send(CMD_START, 4'd15, COORD_MAX, COORD_MAX);
		send(CMD_STEP,  4'd15, '0, '0);
		send(CMD_STEP,  4'd15, '0, '0);
		send(CMD_SPARE, 4'd15, COORD_MAX, COORD_MIN);
		send(CMD_START, 4'd0,  '0, '0);
		send(CMD_STEP,  4'd10, '1, '1);
		send(CMD_STEP,  4'd5,  '0, '0);
		send(CMD_STEP,  4'd10, '0, '0);
		send(CMD_START, 4'd7,  -1, -1);
		send(CMD_STEP,  4'd0,  '0, '0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       f = '0;
				1:       f = FACTOR_ONE;
				2:       f = '1;
				3:       f = 17'd1;
				4:       f = FACTOR_ONE - 17'd1;
				5:       f = FACTOR_RESET;
				default: f = ($urandom_range(0, 2) == 0) ? FACTOR_W'($urandom_range(65537, 131071))
				                                         : FACTOR_W'($urandom_range(0, 65536));
			endcase
			settle();
			write_factor(f);
			gap_odds = (p % 2 == 0) ? 3 : 10;
			if (p == PHASES - 1)
				quiet = 1'b1;
			repeat (PHASE_ITEMS) random_item();
		end
		settle();

		$display("Covered %0d loads, %0d starts, %0d steps and %0d unused commands",
			n_load, n_start, n_step, n_spare);
		$display("across %0d step factor settings, with random stalls on both channels.",
			n_write + 1);
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
